>>> rtl/core/spp_pkg.sv
package spp_pkg;

  // divider geometry
  localparam int QUOT_W      = 41;
  localparam int PROJ_DEN_W  = 32;
  localparam int DISP_DEN_W  = 41;
  localparam int PROJ_NUM_W  = PROJ_DEN_W + QUOT_W;
  localparam int DISP_NUM_W  = DISP_DEN_W + QUOT_W;

  localparam logic [DISP_DEN_W-1:0] DISP_SCALE = 41'd1000;
  localparam logic [QUOT_W-1:0]     PROJ_CLAMP = 41'h100_0000_0000;
  localparam logic [QUOT_W:0]       DISP_MAX   = 42'h7FFF_FFFF;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ROT_ROW0  = 3'd0,
    REG_ROT_ROW1  = 3'd1,
    REG_ROT_ROW2  = 3'd2,
    REG_FOCAL_X   = 3'd3,
    REG_FOCAL_Y   = 3'd4,
    REG_CENTER_X  = 3'd5,
    REG_CENTER_Y  = 3'd6,
    REG_BASELINE  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [15:0] label_x;
    logic signed [15:0] label_y;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_in_t;

  typedef struct packed {
    logic signed [15:0] out_label_x;
    logic signed [15:0] out_label_y;
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
    logic signed [31:0] disparity;
    logic               no_depth;
  } point_out_t;

  // data that travels beside the dividers
  typedef struct packed {
    logic signed [15:0] label_x;
    logic signed [15:0] label_y;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               neg_x;
    logic               neg_y;
    logic               no_depth;
    logic               ovf_x;
    logic               ovf_y;
    logic               ovf_d;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

>>> rtl/core/spp_div.sv
module spp_div import spp_pkg::*; #(
  parameter int DEN_W = 32,
  parameter int Q_W   = 41
) (
  input  logic               clk,
  input  logic               en,
  input  logic [DEN_W+Q_W-1:0] num,
  input  logic [DEN_W-1:0]   den,
  output logic [Q_W-1:0]     quot,
  output logic [DEN_W-1:0]   rem,
  output logic [DEN_W-1:0]   den_out
);

  // one quotient bit per stage; numerator bits shift out as quotient bits shift in
  logic [DEN_W-1:0] rem_q  [Q_W];
  logic [Q_W-1:0]   bits_q [Q_W];
  logic [DEN_W-1:0] den_q  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   bits_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = num[DEN_W+Q_W-1:Q_W];
      assign bits_in = num[Q_W-1:0];
      assign den_in  = den;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign bits_in = bits_q[k-1];
      assign den_in  = den_q[k-1];
    end

    // trial subtract
    assign trial = {rem_in, bits_in[Q_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        bits_q[k] <= {bits_in[Q_W-2:0], ge};
        den_q[k]  <= den_in;
      end
    end
  end

  assign quot    = bits_q[Q_W-1];
  assign rem     = rem_q[Q_W-1];
  assign den_out = den_q[Q_W-1];

endmodule

>>> rtl/core/stereo_point_projector_core.sv
// stereo point projector
// input channel item (valid/ready) carries two grid labels and a point in
// signed Q16.16 metres; output channel result (valid/ready) carries the labels,
// the rotated point, the projected pixel and the stereo disparity, one result
// per input transaction, in order.
// the result passes through one product stage, 41 restoring-divider stages
// (one quotient bit each) and the rounding/output stage. throughput: one
// transaction per cycle while the receiver does not stall.
// the whole pipeline advances together; when the receiver stalls with a
// result waiting, item_ready falls and every stage holds its contents.
// configuration through the APB port, 64-bit data, register i at byte 8*i;
// write only while the pipeline is empty.
// reset clears all valid bits and loads the identity rotation, unit focal
// lengths, zero principal point and zero baseline.
module stereo_point_projector_core import spp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  point_in_t   item,
  output logic        result_valid,
  input  logic        result_ready,
  output point_out_t  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [47:0] rot_row [3];
  logic [31:0] focal_x;
  logic [31:0] focal_y;
  logic [31:0] center_x;
  logic [31:0] center_y;
  logic [31:0] baseline;
  reg_index_t  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0] <= 48'h0000_0000_4000;
      rot_row[1] <= 48'h0000_4000_0000;
      rot_row[2] <= 48'h4000_0000_0000;
      focal_x    <= 32'h0001_0000;
      focal_y    <= 32'h0001_0000;
      center_x   <= '0;
      center_y   <= '0;
      baseline   <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_ROT_ROW0: rot_row[0] <= pwdata[47:0];
        REG_ROT_ROW1: rot_row[1] <= pwdata[47:0];
        REG_ROT_ROW2: rot_row[2] <= pwdata[47:0];
        REG_FOCAL_X:  focal_x    <= pwdata[31:0];
        REG_FOCAL_Y:  focal_y    <= pwdata[31:0];
        REG_CENTER_X: center_x   <= pwdata[31:0];
        REG_CENTER_Y: center_y   <= pwdata[31:0];
        REG_BASELINE: baseline   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_ROT_ROW0: prdata = {16'b0, rot_row[0]};
      REG_ROT_ROW1: prdata = {16'b0, rot_row[1]};
      REG_ROT_ROW2: prdata = {16'b0, rot_row[2]};
      REG_FOCAL_X:  prdata = {32'b0, focal_x};
      REG_FOCAL_Y:  prdata = {32'b0, focal_y};
      REG_CENTER_X: prdata = {32'b0, center_x};
      REG_CENTER_Y: prdata = {32'b0, center_y};
      REG_BASELINE: prdata = {32'b0, baseline};
      default:      prdata = '0;
    endcase
  end

  // pipeline advance
  logic adv;
  logic out_v;
  assign adv        = !out_v || result_ready;
  assign item_ready = adv;

  // product stage
  logic               s1_v;
  logic signed [47:0] s1_prod [3][3];
  logic [63:0]        s1_num_x;
  logic [63:0]        s1_num_y;
  logic [63:0]        s1_num_d;
  logic [DISP_DEN_W-1:0] s1_den_d;
  logic [31:0]        s1_zm;
  logic               s1_neg_x;
  logic               s1_neg_y;
  logic               s1_no_depth;
  logic signed [15:0] s1_label_x;
  logic signed [15:0] s1_label_y;

  logic [31:0] mag_x;
  logic [31:0] mag_y;
  assign mag_x = item.point_x[31] ? 32'(-item.point_x) : item.point_x;
  assign mag_y = item.point_y[31] ? 32'(-item.point_y) : item.point_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        s1_prod[r][0] <= $signed(rot_row[r][15:0])  * item.point_x;
        s1_prod[r][1] <= $signed(rot_row[r][31:16]) * item.point_y;
        s1_prod[r][2] <= $signed(rot_row[r][47:32]) * item.point_z;
      end
      s1_num_x    <= mag_x * focal_x;
      s1_num_y    <= mag_y * focal_y;
      s1_num_d    <= baseline * focal_x;
      s1_den_d    <= {9'b0, item.point_z[31:0]} * DISP_SCALE;
      s1_zm       <= item.point_z;
      s1_neg_x    <= item.point_x[31];
      s1_neg_y    <= item.point_y[31];
      s1_no_depth <= item.point_z[31] || (item.point_z == '0);
      s1_label_x  <= item.label_x;
      s1_label_y  <= item.label_y;
    end
  end

  // rotation rounding and quotient overflow check
  logic signed [31:0] rot [3];
  logic ovf_x;
  logic ovf_y;
  logic ovf_d;

  always_comb begin
    logic signed [49:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = 50'(s1_prod[r][0]) + 50'(s1_prod[r][1]) + 50'(s1_prod[r][2]) + 50'sd8192;
      rot[r] = sat32(64'(acc >>> 14));
    end
  end

  assign ovf_x = {9'b0, s1_num_x[63:QUOT_W]} >= s1_zm;
  assign ovf_y = {9'b0, s1_num_y[63:QUOT_W]} >= s1_zm;
  assign ovf_d = {18'b0, s1_num_d[63:QUOT_W]} >= s1_den_d;

  // dividers
  logic [QUOT_W-1:0]     q_x, q_y, q_d;
  logic [PROJ_DEN_W-1:0] r_x, r_y, dn_x, dn_y;
  logic [DISP_DEN_W-1:0] r_d, dn_d;

  spp_div #(.DEN_W(PROJ_DEN_W), .Q_W(QUOT_W)) u_div_x (
    .clk(clk), .en(adv),
    .num(ovf_x ? '0 : {9'b0, s1_num_x}), .den(s1_zm),
    .quot(q_x), .rem(r_x), .den_out(dn_x)
  );

  spp_div #(.DEN_W(PROJ_DEN_W), .Q_W(QUOT_W)) u_div_y (
    .clk(clk), .en(adv),
    .num(ovf_y ? '0 : {9'b0, s1_num_y}), .den(s1_zm),
    .quot(q_y), .rem(r_y), .den_out(dn_y)
  );

  spp_div #(.DEN_W(DISP_DEN_W), .Q_W(QUOT_W)) u_div_d (
    .clk(clk), .en(adv),
    .num(ovf_d ? '0 : {18'b0, s1_num_d}), .den(s1_den_d),
    .quot(q_d), .rem(r_d), .den_out(dn_d)
  );

  // side data aligned with the divider stages
  side_t side   [QUOT_W];
  logic  side_v [QUOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QUOT_W; k++) begin
        side_v[k] <= 1'b0;
      end
    end else if (adv) begin
      side_v[0] <= s1_v;
      for (int k = 1; k < QUOT_W; k++) begin
        side_v[k] <= side_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{label_x: s1_label_x, label_y: s1_label_y,
                   rot_x: rot[0], rot_y: rot[1], rot_z: rot[2],
                   neg_x: s1_neg_x, neg_y: s1_neg_y, no_depth: s1_no_depth,
                   ovf_x: ovf_x, ovf_y: ovf_y, ovf_d: ovf_d};
      for (int k = 1; k < QUOT_W; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // final rounding, sign, principal point and saturation
  side_t sl;
  assign sl = side[QUOT_W-1];

  function automatic logic signed [31:0] finish_proj(
    input logic [QUOT_W-1:0]     q,
    input logic [PROJ_DEN_W-1:0] r,
    input logic [PROJ_DEN_W-1:0] dn,
    input logic                  ovf,
    input logic                  neg,
    input logic [31:0]           ctr
  );
    logic [QUOT_W:0]    qr;
    logic [QUOT_W-1:0]  qc;
    logic signed [63:0] v;
    qr = {1'b0, q} + (QUOT_W+1)'({r, 1'b0} >= {1'b0, dn});
    qc = (ovf || qr > {1'b0, PROJ_CLAMP}) ? PROJ_CLAMP : qr[QUOT_W-1:0];
    v  = neg ? -$signed({23'b0, qc}) : $signed({23'b0, qc});
    return sat32(v + 64'($signed(ctr)));
  endfunction

  logic signed [31:0] px, py, disp;
  logic [QUOT_W:0]    qr_d;

  always_comb begin
    px   = finish_proj(q_x, r_x, dn_x, sl.ovf_x, sl.neg_x, center_x);
    py   = finish_proj(q_y, r_y, dn_y, sl.ovf_y, sl.neg_y, center_y);
    qr_d = {1'b0, q_d} + (QUOT_W+1)'({r_d, 1'b0} >= {1'b0, dn_d});
    disp = (sl.ovf_d || qr_d > DISP_MAX) ? 32'sh7FFF_FFFF : $signed(qr_d[31:0]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= side_v[QUOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.out_label_x <= sl.label_x;
      result.out_label_y <= sl.label_y;
      result.rotated_x   <= sl.rot_x;
      result.rotated_y   <= sl.rot_y;
      result.rotated_z   <= sl.rot_z;
      result.pixel_x     <= sl.no_depth ? '0 : px;
      result.pixel_y     <= sl.no_depth ? '0 : py;
      result.disparity   <= sl.no_depth ? '0 : disp;
      result.no_depth    <= sl.no_depth;
    end
  end

  assign result_valid = out_v;

  // checks
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> s1_v)
    else $error("accepted transaction did not enter the product stage");

  a_no_depth_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.no_depth |->
      result.pixel_x == '0 && result.pixel_y == '0 && result.disparity == '0)
    else $error("no depth result carries nonzero projection");

  a_disp_positive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !result.disparity[31])
    else $error("negative disparity");

endmodule
